>>> rtl/core/plvs_pkg.sv
// shared types and constants of the point-light vertex shader
// no dependencies; imported by every module of the block
`default_nettype none

package plvs_pkg;

    localparam int POS_W   = 24;
    localparam int NORM_W  = 16;
    localparam int COL_W   = 8;
    localparam int BRT_W   = 16;
    localparam int CIDX_W  = 8;
    localparam int CDATA_W = 8;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] REG_AMBIENT     = 8'd0;
    localparam logic [CIDX_W-1:0] REG_LIGHT_COUNT = 8'd1;

    // request codes
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_SHADE = 1'b1;

    // 0.01 * d^2 against brightness in Q12.4 with d^2 in Q16: b * 409600
    localparam int BRIGHT_SCALE = 409600;
    localparam int NDL_MAX      = 65535;

    typedef struct packed {
        logic signed [POS_W-1:0] px;
        logic signed [POS_W-1:0] py;
        logic signed [POS_W-1:0] pz;
        logic [COL_W-1:0]        red;
        logic [COL_W-1:0]        green;
        logic [COL_W-1:0]        blue;
        logic [BRT_W-1:0]        bright;
    } light_entry_t;

    typedef enum logic [1:0] {
        MODE_SQRT,
        MODE_DIV
    } unit_mode_t;

    typedef struct packed {
        logic       start;
        unit_mode_t mode;
        logic       q17;    // 17 quotient bits instead of 16
    } unit_cmd_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_M_XX,
        ST_M_YY,
        ST_M_ZZ,
        ST_M_NX,
        ST_M_NY,
        ST_M_NZ,
        ST_M_BS,
        ST_CHECK,
        ST_SQRT,
        ST_NDL,
        ST_NDL_WAIT,
        ST_ATT,
        ST_ATT_WAIT,
        ST_M_W,
        ST_M_R,
        ST_M_G,
        ST_M_B,
        ST_ACC_B,
        ST_NEXT,
        ST_FIN
    } state_t;

endpackage

`default_nettype wire

>>> rtl/core/plvs_light_table.sv
// light table: one write port, one registered read port
// depends on plvs_pkg for the entry type
`default_nettype none

module plvs_light_table #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire                      aclk,
    input  wire                      we,
    input  wire [AW-1:0]             waddr,
    input  wire plvs_pkg::light_entry_t wdata,
    input  wire [AW-1:0]             raddr,
    output plvs_pkg::light_entry_t   rdata
);
    import plvs_pkg::*;

    light_entry_t mem [DEPTH];
    light_entry_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/core/plvs_iter_unit.sv
// shared bit-serial unit: integer square root and restoring division
// one result bit per cycle; depends on plvs_pkg for the command struct
`default_nettype none

module plvs_iter_unit (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire plvs_pkg::unit_cmd_t cmd,
    input  wire [62:0]          op_a,    // radicand or dividend
    input  wire [50:0]          op_b,    // divisor
    output logic [31:0]         result,
    output logic                done
);
    import plvs_pkg::*;

    logic [62:0] rem_reg,  rem_next;
    logic [62:0] res_reg,  res_next;
    logic [62:0] bit_reg,  bit_next;   // sqrt weight, or dividend bits for division
    logic [50:0] div_reg;
    logic [4:0]  cnt_reg,  cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic        sqrt_reg;

    logic [62:0] cmp_a, cmp_b, diff;
    logic        ge;

    always_comb begin
        if (sqrt_reg) begin
            cmp_a = rem_reg;
            cmp_b = res_reg + bit_reg;
        end else begin
            cmp_a = {rem_reg[61:0], bit_reg[16]};
            cmp_b = {12'd0, div_reg};
        end
        ge   = cmp_a >= cmp_b;
        diff = cmp_a - cmp_b;
    end

    always_comb begin
        rem_next  = rem_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (cmd.start) begin
            busy_next = 1'b1;
            res_next  = '0;
            if (cmd.mode == MODE_SQRT) begin
                rem_next = op_a;
                bit_next = 63'd1 << 62;
                cnt_next = 5'd31;
            end else if (cmd.q17) begin
                rem_next = op_a >> 17;
                bit_next = {46'd0, op_a[16:0]};
                cnt_next = 5'd16;
            end else begin
                rem_next = op_a >> 16;
                bit_next = {46'd0, op_a[15:0], 1'b0};
                cnt_next = 5'd15;
            end
        end else if (busy_reg) begin
            if (sqrt_reg) begin
                rem_next = ge ? diff : rem_reg;
                res_next = (res_reg >> 1) + (ge ? bit_reg : 63'd0);
                bit_next = bit_reg >> 2;
            end else begin
                rem_next = ge ? diff : cmp_a;
                res_next = {res_reg[61:0], ge};
                bit_next = bit_reg << 1;
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
        cnt_reg <= cnt_next;
        if (cmd.start) begin
            div_reg  <= op_b;
            sqrt_reg <= (cmd.mode == MODE_SQRT);
        end
    end

    assign result = res_reg[31:0];
    assign done   = done_reg;

endmodule

`default_nettype wire

>>> rtl/core/point_light_vertex_shader.sv
// point-light vertex shader top level: sequencer, shared multiplier, accumulators
// depends on plvs_pkg, plvs_light_table and plvs_iter_unit
//
// Usage:
//   s_ channel: one word per request. req_type 0 stores a light entry
//   (position, colour, brightness) at light_index; indexes at or above
//   MAX_LIGHTS are dropped. req_type 1 shades a vertex and returns one
//   m_ word with the lit colour.
//   cfg channel: cfg_index 0 is ambient_level, 1 is light_count; always ready.
//   Write it only while no shade request is in flight.
//   Each light that faces the vertex takes a square root and two divisions
//   on the shared bit-serial unit, or only one division when n.l saturates;
//   a light that is skipped does not use the unit.
//   s_ready is high only while the sequencer is idle. The result sits in an
//   output register, so a new request is taken while m_valid waits for
//   m_ready; a finished shade waits if that register is still full.
//   Reset clears the configuration registers, m_valid and the sequencer. The light
//   table is not cleared and must be written before it is used.
`default_nettype none

module point_light_vertex_shader #(
    parameter int MAX_LIGHTS = 16
) (
    input  wire         aclk,
    input  wire         aresetn,

    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire [7:0]   cfg_index,
    input  wire [7:0]   cfg_data,

    input  wire         s_valid,
    output logic        s_ready,
    input  wire         s_req_type,
    input  wire [3:0]   s_light_index,
    input  wire signed [23:0] s_pos_x,
    input  wire signed [23:0] s_pos_y,
    input  wire signed [23:0] s_pos_z,
    input  wire signed [15:0] s_norm_x,
    input  wire signed [15:0] s_norm_y,
    input  wire signed [15:0] s_norm_z,
    input  wire [7:0]   s_light_red,
    input  wire [7:0]   s_light_green,
    input  wire [7:0]   s_light_blue,
    input  wire [15:0]  s_light_brightness,

    output logic        m_valid,
    input  wire         m_ready,
    output logic [7:0]  m_out_red,
    output logic [7:0]  m_out_green,
    output logic [7:0]  m_out_blue
);
    import plvs_pkg::*;

    localparam int AW = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;
    localparam int CW = $clog2(MAX_LIGHTS + 1);

    state_t state_reg, state_next;

    logic [7:0]  ambient_reg;
    logic [4:0]  light_count_reg;

    logic signed [23:0] vx_reg, vy_reg, vz_reg;
    logic signed [15:0] nx_reg, ny_reg, nz_reg;
    logic [CW-1:0] cnt_reg, count_reg;

    logic signed [24:0] dx_reg, dy_reg, dz_reg;
    logic [49:0]        d2_reg;
    logic signed [42:0] dot_reg;
    logic [34:0]        bs_reg;
    logic [31:0]        len_reg;
    logic [15:0]        ndl_reg;
    logic [16:0]        att_reg;
    logic [32:0]        w_reg;
    logic [46:0]        acc_r_reg, acc_g_reg, acc_b_reg;

    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] mul_full;
    logic signed [49:0] prod_reg;

    logic        m_valid_reg;
    logic [7:0]  out_r_reg, out_g_reg, out_b_reg;

    unit_cmd_t     ucmd;
    logic [62:0]   u_op_a;
    logic [50:0]   u_op_b;
    logic [31:0]   u_result;
    logic          u_done;

    light_entry_t  wr_entry, rd_entry;
    logic          tbl_we;
    logic          s_fire;
    logic          out_free;
    logic          ndl_sat;
    logic [48:0]   dot64;

    // round half up from Q30 and clip to 255
    function automatic logic [7:0] sat_channel(input logic [46:0] acc);
        logic [46:0] rnd;
        rnd = acc + 47'(1 << 29);
        if (rnd[46:30] > 17'd255) begin
            sat_channel = 8'd255;
        end else begin
            sat_channel = rnd[37:30];
        end
    endfunction

    // ---------------------------------------------------------------
    plvs_light_table #(
        .DEPTH (MAX_LIGHTS),
        .AW    (AW)
    ) u_table (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (AW'(s_light_index)),
        .wdata (wr_entry),
        .raddr (cnt_reg[AW-1:0]),
        .rdata (rd_entry)
    );

    plvs_iter_unit u_iter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (ucmd),
        .op_a    (u_op_a),
        .op_b    (u_op_b),
        .result  (u_result),
        .done    (u_done)
    );

    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign dot64    = {1'b0, dot_reg[41:0], 6'd0};
    assign ndl_sat  = (dot64[48:16] >= {1'b0, len_reg});
    assign mul_full = mul_a * mul_b;

    always_comb begin
        wr_entry.px     = s_pos_x;
        wr_entry.py     = s_pos_y;
        wr_entry.pz     = s_pos_z;
        wr_entry.red    = s_light_red;
        wr_entry.green  = s_light_green;
        wr_entry.blue   = s_light_blue;
        wr_entry.bright = s_light_brightness;
        tbl_we = s_fire && (s_req_type == REQ_WRITE)
                 && (32'(s_light_index) < MAX_LIGHTS);
    end

    // ---------------------------------------------------------------
    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire && s_req_type == REQ_SHADE) begin
                    if (light_count_reg == 5'd0) begin
                        state_next = ST_FIN;
                    end else begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:  state_next = ST_LOAD;
            ST_LOAD:  state_next = ST_M_XX;
            ST_M_XX:  state_next = ST_M_YY;
            ST_M_YY:  state_next = ST_M_ZZ;
            ST_M_ZZ:  state_next = ST_M_NX;
            ST_M_NX:  state_next = ST_M_NY;
            ST_M_NY:  state_next = ST_M_NZ;
            ST_M_NZ:  state_next = ST_M_BS;
            ST_M_BS:  state_next = ST_CHECK;
            ST_CHECK: begin
                if (d2_reg == '0 || dot_reg <= 0) begin
                    state_next = ST_NEXT;
                end else begin
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (u_done) begin
                    state_next = ST_NDL;
                end
            end
            ST_NDL: begin
                if (ndl_sat) begin
                    state_next = ST_ATT_WAIT;
                end else begin
                    state_next = ST_NDL_WAIT;
                end
            end
            ST_NDL_WAIT: begin
                if (u_done) begin
                    state_next = ST_ATT;
                end
            end
            ST_ATT:   state_next = ST_ATT_WAIT;
            ST_ATT_WAIT: begin
                if (u_done) begin
                    state_next = ST_M_W;
                end
            end
            ST_M_W:   state_next = ST_M_R;
            ST_M_R:   state_next = ST_M_G;
            ST_M_G:   state_next = ST_M_B;
            ST_M_B:   state_next = ST_ACC_B;
            ST_ACC_B: state_next = ST_NEXT;
            ST_NEXT: begin
                if (cnt_reg + CW'(1) >= count_reg) begin
                    state_next = ST_FIN;
                end else begin
                    state_next = ST_READ;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // outputs of the sequencer: handshake, unit command, multiplier operands
    always_comb begin
        s_ready   = (state_reg == ST_IDLE);
        cfg_ready = 1'b1;
        ucmd      = '{start: 1'b0, mode: MODE_SQRT, q17: 1'b0};
        u_op_a    = {1'b0, d2_reg, 12'd0};
        u_op_b    = 51'(len_reg);
        mul_a     = '0;
        mul_b     = '0;
        unique case (state_reg)
            ST_CHECK: begin
                ucmd.start = !(d2_reg == '0 || dot_reg <= 0);
            end
            ST_NDL: begin
                ucmd.start = 1'b1;
                ucmd.mode  = MODE_DIV;
                if (ndl_sat) begin
                    ucmd.q17 = 1'b1;
                    u_op_a   = {12'd0, bs_reg, 16'd0};
                    u_op_b   = 51'(bs_reg) + 51'(d2_reg);
                end else begin
                    u_op_a   = {14'd0, dot64};
                end
            end
            ST_ATT: begin
                ucmd.start = 1'b1;
                ucmd.mode  = MODE_DIV;
                ucmd.q17   = 1'b1;
                u_op_a     = {12'd0, bs_reg, 16'd0};
                u_op_b     = 51'(bs_reg) + 51'(d2_reg);
            end
            ST_M_XX: begin mul_a = 34'(dx_reg); mul_b = 34'(dx_reg); end
            ST_M_YY: begin mul_a = 34'(dy_reg); mul_b = 34'(dy_reg); end
            ST_M_ZZ: begin mul_a = 34'(dz_reg); mul_b = 34'(dz_reg); end
            ST_M_NX: begin mul_a = 34'(nx_reg); mul_b = 34'(dx_reg); end
            ST_M_NY: begin mul_a = 34'(ny_reg); mul_b = 34'(dy_reg); end
            ST_M_NZ: begin mul_a = 34'(nz_reg); mul_b = 34'(dz_reg); end
            ST_M_BS: begin
                mul_a = {18'd0, rd_entry.bright};
                mul_b = 34'(BRIGHT_SCALE);
            end
            ST_M_W: begin
                mul_a = {18'd0, ndl_reg};
                mul_b = {17'd0, att_reg};
            end
            ST_M_R: begin
                mul_a = {26'd0, rd_entry.red};
                mul_b = {1'b0, prod_reg[32:0]};
            end
            ST_M_G: begin
                mul_a = {26'd0, rd_entry.green};
                mul_b = {1'b0, w_reg};
            end
            ST_M_B: begin
                mul_a = {26'd0, rd_entry.blue};
                mul_b = {1'b0, w_reg};
            end
            default: begin
            end
        endcase
    end

    // ---------------------------------------------------------------
    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            ambient_reg     <= '0;
            light_count_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_AMBIENT) begin
                    ambient_reg <= cfg_data;
                end else if (cfg_index == REG_LIGHT_COUNT) begin
                    light_count_reg <= cfg_data[4:0];
                end
            end
            if (state_reg == ST_FIN && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        prod_reg <= mul_full[49:0];
        if (s_fire && s_req_type == REQ_SHADE) begin
            vx_reg    <= s_pos_x;
            vy_reg    <= s_pos_y;
            vz_reg    <= s_pos_z;
            nx_reg    <= s_norm_x;
            ny_reg    <= s_norm_y;
            nz_reg    <= s_norm_z;
            cnt_reg   <= '0;
            acc_r_reg <= {9'd0, ambient_reg, 30'd0};
            acc_g_reg <= {9'd0, ambient_reg, 30'd0};
            acc_b_reg <= {9'd0, ambient_reg, 30'd0};
            if (32'(light_count_reg) > MAX_LIGHTS) begin
                count_reg <= CW'(MAX_LIGHTS);
            end else begin
                count_reg <= CW'(light_count_reg);
            end
        end
        unique case (state_reg)
            ST_LOAD: begin
                dx_reg <= 25'(rd_entry.px) - 25'(vx_reg);
                dy_reg <= 25'(rd_entry.py) - 25'(vy_reg);
                dz_reg <= 25'(rd_entry.pz) - 25'(vz_reg);
            end
            ST_M_YY: d2_reg  <= prod_reg[49:0];
            ST_M_ZZ: d2_reg  <= d2_reg + prod_reg[49:0];
            ST_M_NX: d2_reg  <= d2_reg + prod_reg[49:0];
            ST_M_NY: dot_reg <= prod_reg[42:0];
            ST_M_NZ: dot_reg <= dot_reg + prod_reg[42:0];
            ST_M_BS: dot_reg <= dot_reg + prod_reg[42:0];
            ST_CHECK: bs_reg <= prod_reg[34:0];
            ST_SQRT: begin
                if (u_done) begin
                    len_reg <= u_result;
                end
            end
            ST_NDL: begin
                if (ndl_sat) begin
                    ndl_reg <= 16'(NDL_MAX);
                end
            end
            ST_NDL_WAIT: begin
                if (u_done) begin
                    ndl_reg <= u_result[15:0];
                end
            end
            ST_ATT_WAIT: begin
                if (u_done) begin
                    att_reg <= u_result[16:0];
                end
            end
            ST_M_R:   w_reg     <= prod_reg[32:0];
            ST_M_G:   acc_r_reg <= acc_r_reg + 47'(prod_reg[40:0]);
            ST_M_B:   acc_g_reg <= acc_g_reg + 47'(prod_reg[40:0]);
            ST_ACC_B: acc_b_reg <= acc_b_reg + 47'(prod_reg[40:0]);
            ST_NEXT:  cnt_reg   <= cnt_reg + CW'(1);
            default: begin
            end
        endcase
        if (state_reg == ST_FIN && out_free) begin
            out_r_reg <= sat_channel(acc_r_reg);
            out_g_reg <= sat_channel(acc_g_reg);
            out_b_reg <= sat_channel(acc_b_reg);
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_red   = out_r_reg;
    assign m_out_green = out_g_reg;
    assign m_out_blue  = out_b_reg;

    // ---------------------------------------------------------------
    a_done_waited: assert property (@(posedge aclk) disable iff (!aresetn)
        u_done |-> (state_reg == ST_SQRT || state_reg == ST_NDL_WAIT
                    || state_reg == ST_ATT_WAIT))
        else $error("iterative unit finished with no state waiting for it");

    a_read_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ) |-> (cnt_reg < count_reg))
        else $error("light table read beyond the active light count");

    a_att_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_M_W) |-> (att_reg <= 17'd65536))
        else $error("attenuation above one");

    a_fin_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN && out_free) |=> (m_valid && state_reg == ST_IDLE))
        else $error("finished shade did not reach the output register");

endmodule

`default_nettype wire
